### hw/rtl/bmm_pkg.sv
package bmm_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_INNER = 16;
    localparam int MAX_COLS  = 8;

    localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH = MAX_INNER * MAX_COLS;
    localparam int ADDR_W  = $clog2(A_DEPTH > B_DEPTH ? A_DEPTH : B_DEPTH);

    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int RES_W  = 32;
    // one guard bit per doubling of the term count, plus one spare
    localparam int ACC_W  = PROD_W + $clog2(MAX_INNER) + 1;

    localparam int ROWS_W  = 4;
    localparam int INNER_W = 5;
    localparam int COLS_W  = 4;
    localparam int CFG_W   = 5;
    localparam int CIDX_W  = 2;

    localparam int ROW_IDX_W = 3;
    localparam int COL_IDX_W = 3;
    localparam int TERM_W    = $clog2(MAX_INNER);
    localparam int CNT_W     = ROWS_W + INNER_W;

    localparam int OUT_DATA_W = RES_W + ROW_IDX_W + COL_IDX_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    localparam logic [CIDX_W-1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INNER_K = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLS_N  = 2'd2;

    localparam logic MAT_A = 1'b0;
    localparam logic MAT_B = 1'b1;

    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 4'd8;
    localparam logic [INNER_W-1:0] INNER_RESET = 5'd16;
    localparam logic [COLS_W-1:0]  COLS_RESET  = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctl;

endpackage

### hw/rtl/bmm_ram.sv
module bmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bmm_mac.sv
module bmm_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bmm_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [bmm_pkg::ELEM_W-1:0]     i_a,
    input  logic signed [bmm_pkg::ELEM_W-1:0]     i_b,
    output logic                                  o_busy,
    output logic        [bmm_pkg::RES_W-1:0]      o_result
);

    logic                                r_p1_vld;
    logic                                r_p2_vld;
    logic signed [bmm_pkg::PROD_W-1:0]   r_prod;
    logic signed [bmm_pkg::ACC_W-1:0]    r_acc;
    logic signed [bmm_pkg::PROD_W-1:0]   w_prod;
    logic [bmm_pkg::ACC_W-bmm_pkg::RES_W:0] w_top;

    assign w_prod = bmm_pkg::PROD_W'(i_a) * bmm_pkg::PROD_W'(i_b);

    // read data lands in the cycle after issue, the product in the cycle after that
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_ctl.issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_prod <= w_prod;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + bmm_pkg::ACC_W'(r_prod);
        end
    end

    assign o_busy = r_p1_vld | r_p2_vld;

    // in range when every bit above the result sign matches it
    assign w_top = r_acc[bmm_pkg::ACC_W-1:bmm_pkg::RES_W-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            o_result = r_acc[bmm_pkg::RES_W-1:0];
        end else if (r_acc[bmm_pkg::ACC_W-1]) begin
            o_result = {1'b1, {(bmm_pkg::RES_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(bmm_pkg::RES_W-1){1'b1}}};
        end
    end

endmodule

### hw/rtl/batched_matrix_multiply.sv
// channel   direction  handshake                 payload
// s_axis    in         i_s_axis_tvalid/o_..ready tdata: element_value; tuser: which_matrix
// m_axis    out        o_m_axis_tvalid/i_..ready tdata: result, row, col; tlast: last_of_slice
// cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// An A item or a non-final B item is written to its element RAM. The final B item
// of a slice starts the shared MAC: each of the M*N results takes K reads of the
// two element RAMs, a drain of the MAC pipeline and a transfer on the output,
// which can stall; while a slice is computed and sent, s_axis is not ready.
// Reset is synchronous, active low; the element RAMs are not cleared.
module batched_matrix_multiply (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [bmm_pkg::ELEM_W-1:0]         i_s_axis_tdata,  // [15:0] element_value
    input  logic                               i_s_axis_tuser,  // [0] which_matrix
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] result_value, [34:32] row_index, [37:35] col_index, [39:38] zero
    output logic [bmm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast,  // last_of_slice
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bmm_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [bmm_pkg::CFG_W-1:0]          i_cfg_data
);

    bmm_pkg::t_state r_state, n_state;

    logic [bmm_pkg::ROWS_W-1:0]    r_rows_m;
    logic [bmm_pkg::INNER_W-1:0]   r_inner_k;
    logic [bmm_pkg::COLS_W-1:0]    r_cols_n;
    logic [bmm_pkg::ADDR_W-1:0]    r_a_pos, n_a_pos;
    logic [bmm_pkg::ADDR_W-1:0]    r_b_pos, n_b_pos;
    logic [bmm_pkg::ROW_IDX_W-1:0] r_i, n_i;
    logic [bmm_pkg::COL_IDX_W-1:0] r_j, n_j;
    logic [bmm_pkg::TERM_W-1:0]    r_t, n_t;
    logic [bmm_pkg::ADDR_W-1:0]    r_a_row, n_a_row;
    logic [bmm_pkg::ADDR_W-1:0]    r_a_addr, n_a_addr;
    logic [bmm_pkg::ADDR_W-1:0]    r_b_addr, n_b_addr;

    logic [bmm_pkg::ROWS_W-1:0]    w_m;
    logic [bmm_pkg::INNER_W-1:0]   w_k;
    logic [bmm_pkg::COLS_W-1:0]    w_n;
    logic [bmm_pkg::CNT_W-1:0]     w_mk;
    logic [bmm_pkg::CNT_W-1:0]     w_kn;
    logic [bmm_pkg::ADDR_W-1:0]    w_a_wr;
    logic [bmm_pkg::ADDR_W-1:0]    w_b_wr;
    logic [bmm_pkg::CNT_W-1:0]     w_a_inc;
    logic [bmm_pkg::CNT_W-1:0]     w_b_inc;
    logic                          w_in_acc;
    logic                          w_cfg_acc;
    logic                          w_a_we;
    logic                          w_b_we;
    logic                          w_last_i;
    logic                          w_last_j;
    logic [bmm_pkg::ELEM_W-1:0]    w_a_rd;
    logic [bmm_pkg::ELEM_W-1:0]    w_b_rd;
    logic                          w_mac_busy;
    logic [bmm_pkg::RES_W-1:0]     w_result;
    bmm_pkg::t_mac_ctl             w_mac_ctl;

    // zero sizes act as 1, oversize as the maximum
    always_comb begin
        if (r_rows_m == '0) begin
            w_m = bmm_pkg::ROWS_W'(1);
        end else if (r_rows_m > bmm_pkg::ROWS_W'(bmm_pkg::MAX_ROWS)) begin
            w_m = bmm_pkg::ROWS_W'(bmm_pkg::MAX_ROWS);
        end else begin
            w_m = r_rows_m;
        end
        if (r_inner_k == '0) begin
            w_k = bmm_pkg::INNER_W'(1);
        end else if (r_inner_k > bmm_pkg::INNER_W'(bmm_pkg::MAX_INNER)) begin
            w_k = bmm_pkg::INNER_W'(bmm_pkg::MAX_INNER);
        end else begin
            w_k = r_inner_k;
        end
        if (r_cols_n == '0) begin
            w_n = bmm_pkg::COLS_W'(1);
        end else if (r_cols_n > bmm_pkg::COLS_W'(bmm_pkg::MAX_COLS)) begin
            w_n = bmm_pkg::COLS_W'(bmm_pkg::MAX_COLS);
        end else begin
            w_n = r_cols_n;
        end
    end

    assign w_mk = bmm_pkg::CNT_W'(w_m) * bmm_pkg::CNT_W'(w_k);
    assign w_kn = bmm_pkg::CNT_W'(w_k) * bmm_pkg::CNT_W'(w_n);

    assign o_s_axis_tready = (r_state == bmm_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign w_a_we          = w_in_acc && (i_s_axis_tuser == bmm_pkg::MAT_A);
    assign w_b_we          = w_in_acc && (i_s_axis_tuser == bmm_pkg::MAT_B);

    assign w_a_wr  = (bmm_pkg::CNT_W'(r_a_pos) >= w_mk) ? '0 : r_a_pos;
    assign w_b_wr  = (bmm_pkg::CNT_W'(r_b_pos) >= w_kn) ? '0 : r_b_pos;
    assign w_a_inc = bmm_pkg::CNT_W'(w_a_wr) + bmm_pkg::CNT_W'(1);
    assign w_b_inc = bmm_pkg::CNT_W'(w_b_wr) + bmm_pkg::CNT_W'(1);

    assign w_last_i = (bmm_pkg::ROWS_W'(r_i) == w_m - bmm_pkg::ROWS_W'(1));
    assign w_last_j = (bmm_pkg::COLS_W'(r_j) == w_n - bmm_pkg::COLS_W'(1));

    bmm_ram #(
        .WIDTH (bmm_pkg::ELEM_W),
        .DEPTH (bmm_pkg::A_DEPTH)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_wr),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (r_a_addr),
        .o_rdata (w_a_rd)
    );

    bmm_ram #(
        .WIDTH (bmm_pkg::ELEM_W),
        .DEPTH (bmm_pkg::B_DEPTH)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_wr),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (r_b_addr),
        .o_rdata (w_b_rd)
    );

    bmm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_a      (w_a_rd),
        .i_b      (w_b_rd),
        .o_busy   (w_mac_busy),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bmm_pkg::ST_IDLE;
            r_rows_m  <= bmm_pkg::ROWS_RESET;
            r_inner_k <= bmm_pkg::INNER_RESET;
            r_cols_n  <= bmm_pkg::COLS_RESET;
            r_a_pos   <= '0;
            r_b_pos   <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_t       <= '0;
            r_a_row   <= '0;
            r_a_addr  <= '0;
            r_b_addr  <= '0;
        end else begin
            r_state  <= n_state;
            r_a_pos  <= n_a_pos;
            r_b_pos  <= n_b_pos;
            r_i      <= n_i;
            r_j      <= n_j;
            r_t      <= n_t;
            r_a_row  <= n_a_row;
            r_a_addr <= n_a_addr;
            r_b_addr <= n_b_addr;
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    bmm_pkg::CFG_ROWS_M:  r_rows_m  <= i_cfg_data[bmm_pkg::ROWS_W-1:0];
                    bmm_pkg::CFG_INNER_K: r_inner_k <= i_cfg_data[bmm_pkg::INNER_W-1:0];
                    bmm_pkg::CFG_COLS_N:  r_cols_n  <= i_cfg_data[bmm_pkg::COLS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_a_pos         = r_a_pos;
        n_b_pos         = r_b_pos;
        n_i             = r_i;
        n_j             = r_j;
        n_t             = r_t;
        n_a_row         = r_a_row;
        n_a_addr        = r_a_addr;
        n_b_addr        = r_b_addr;
        w_mac_ctl.clear = 1'b0;
        w_mac_ctl.issue = 1'b0;

        unique case (r_state)
            bmm_pkg::ST_IDLE: begin
                if (w_a_we) begin
                    n_a_pos = (w_a_inc >= w_mk) ? '0 : w_a_inc[bmm_pkg::ADDR_W-1:0];
                end
                if (w_b_we) begin
                    if (w_b_inc >= w_kn) begin
                        // slice complete: start the first dot product
                        n_b_pos         = '0;
                        n_state         = bmm_pkg::ST_MAC;
                        n_i             = '0;
                        n_j             = '0;
                        n_t             = '0;
                        n_a_row         = '0;
                        n_a_addr        = '0;
                        n_b_addr        = '0;
                        w_mac_ctl.clear = 1'b1;
                    end else begin
                        n_b_pos = w_b_inc[bmm_pkg::ADDR_W-1:0];
                    end
                end
            end
            bmm_pkg::ST_MAC: begin
                w_mac_ctl.issue = 1'b1;
                n_a_addr        = r_a_addr + bmm_pkg::ADDR_W'(1);
                n_b_addr        = r_b_addr + bmm_pkg::ADDR_W'(w_n);
                if (bmm_pkg::INNER_W'(r_t) == w_k - bmm_pkg::INNER_W'(1)) begin
                    n_state = bmm_pkg::ST_DRAIN;
                end else begin
                    n_t = r_t + bmm_pkg::TERM_W'(1);
                end
            end
            bmm_pkg::ST_DRAIN: begin
                if (!w_mac_busy) begin
                    n_state = bmm_pkg::ST_OUT;
                end
            end
            bmm_pkg::ST_OUT: begin
                if (i_m_axis_tready) begin
                    if (w_last_j && w_last_i) begin
                        n_state = bmm_pkg::ST_IDLE;
                    end else begin
                        n_state         = bmm_pkg::ST_MAC;
                        n_t             = '0;
                        w_mac_ctl.clear = 1'b1;
                        if (w_last_j) begin
                            n_i      = r_i + bmm_pkg::ROW_IDX_W'(1);
                            n_j      = '0;
                            n_a_row  = r_a_row + bmm_pkg::ADDR_W'(w_k);
                            n_a_addr = r_a_row + bmm_pkg::ADDR_W'(w_k);
                            n_b_addr = '0;
                        end else begin
                            n_j      = r_j + bmm_pkg::COL_IDX_W'(1);
                            n_a_addr = r_a_row;
                            n_b_addr = bmm_pkg::ADDR_W'(r_j + bmm_pkg::COL_IDX_W'(1));
                        end
                    end
                end
            end
            default: n_state = bmm_pkg::ST_IDLE;
        endcase

        // a register write restarts loading of both matrices
        if (w_cfg_acc && (i_cfg_index == bmm_pkg::CFG_ROWS_M ||
                          i_cfg_index == bmm_pkg::CFG_INNER_K ||
                          i_cfg_index == bmm_pkg::CFG_COLS_N)) begin
            n_a_pos = '0;
            n_b_pos = '0;
        end
    end

    assign o_m_axis_tvalid = (r_state == bmm_pkg::ST_OUT);
    assign o_m_axis_tlast  = w_last_i && w_last_j;
    assign o_m_axis_tdata  = {{(bmm_pkg::OUT_TDATA_W - bmm_pkg::OUT_DATA_W){1'b0}},
                              r_j, r_i, w_result};

endmodule

### hw/rtl/bmm_chk.sv
module bmm_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [bmm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // no input is taken while a result is being sent
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a result is pending");

    // the last result of a slice hands back to the input side
    a_slice_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=>
            o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block not idle after end of slice");

    // an A item never starts a computation
    a_a_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == bmm_pkg::MAT_A) |=>
            o_s_axis_tready)
        else $error("A item made the block busy");

endmodule

bind batched_matrix_multiply bmm_chk u_bmm_chk (.*);
